FILE: rtl/core/fraction_reducer_defines.svh
// ----------------------------------------------------------------------------
// fraction_reducer_defines.svh
// Assertion macros shared by the fraction reducer RTL.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_DEFINES_SVH
`define FRACTION_REDUCER_DEFINES_SVH

// same-cycle check, clocked on clk, off during reset
`define FR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// next-cycle check: cause one cycle, effect the next
`define FR_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cause) |=> (effect)) else $error(msg);

`endif

FILE: rtl/core/fr_pkg.sv
// ----------------------------------------------------------------------------
// fr_pkg
// Shared constants and control types of the fraction reducer.
// ----------------------------------------------------------------------------
`default_nettype none

package fr_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	// top level to engine
	typedef struct packed {
		logic start;   // new request, engine idle
		logic bypass;  // a part is not positive: pass unchanged
		logic take;    // result moved to the output register
	} fr_req_t;

	// engine to top level
	typedef struct packed {
		logic busy;    // request held, from start until take
		logic done;    // result ready in the engine
	} fr_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/fr_if.sv
// ----------------------------------------------------------------------------
// fr_if
// Valid/ready channels for fraction requests and reduced results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fr_in_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] numerator_in;
	logic signed [W-1:0] denominator_in;

	modport source (output valid, numerator_in, denominator_in, input ready);
	modport sink   (input valid, numerator_in, denominator_in, output ready);
endinterface

interface fr_out_if #(
	parameter int W = 32
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] numerator_out;
	logic signed [W-1:0] denominator_out;

	modport source (output valid, numerator_out, denominator_out, input ready);
	modport sink   (input valid, numerator_out, denominator_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fr_engine.sv
// ----------------------------------------------------------------------------
// fr_engine
// Binary GCD followed by two restoring divisions, all on one shared
// subtractor under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fraction_reducer_defines.svh"

module fr_engine
	import fr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fr_req_t               req,
	input  wire logic [DATA_WIDTH-1:0] num,
	input  wire logic [DATA_WIDTH-1:0] den,
	output fr_stat_t                   stat,
	output logic      [DATA_WIDTH-1:0] num_red,
	output logic      [DATA_WIDTH-1:0] den_red
);

	localparam int W  = DATA_WIDTH;
	localparam int KW = $clog2(W);

	typedef enum logic [2:0] {
		S_IDLE,
		S_STRIP,
		S_REDUCE,
		S_DIV_N,
		S_DIV_D,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [W-1:0]  a_q, b_q, g_q, num_q, den_q, quo_q, rem_q;
	logic [KW-1:0] k_q, cnt_q;

	logic [W:0]    rem_sh, sub_x, sub_y, diff;
	logic [W-1:0]  quo_nx, rem_nx;
	logic          last;

	// shared subtractor
	always_comb begin
		rem_sh = {rem_q, quo_q[W-1]};
		case (state_q)
			S_REDUCE: begin
				sub_x = {1'b0, b_q};
				sub_y = {1'b0, a_q};
			end
			default: begin
				sub_x = rem_sh;
				sub_y = {1'b0, g_q};
			end
		endcase
		diff   = sub_x - sub_y;
		quo_nx = {quo_q[W-2:0], ~diff[W]};
		rem_nx = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
		last   = (cnt_q == KW'(W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						num_q   <= num;
						den_q   <= den;
						a_q     <= num;
						b_q     <= den;
						k_q     <= '0;
						state_q <= req.bypass ? S_DONE : S_STRIP;
					end
				end
				S_STRIP: begin
					if (a_q[0] || b_q[0]) begin
						state_q <= S_REDUCE;
					end else begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						k_q <= k_q + KW'(1);
					end
				end
				S_REDUCE: begin
					if (b_q == '0) begin
						g_q     <= a_q << k_q;
						quo_q   <= num_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV_N;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else if (diff[W]) begin
						a_q <= b_q;
						b_q <= a_q;
					end else begin
						b_q <= diff[W-1:0];
					end
				end
				S_DIV_N: begin
					if (last) begin
						num_q   <= quo_nx;
						quo_q   <= den_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV_D;
					end else begin
						quo_q <= quo_nx;
						rem_q <= rem_nx;
						cnt_q <= cnt_q + KW'(1);
					end
				end
				S_DIV_D: begin
					if (last) begin
						den_q   <= quo_nx;
						state_q <= S_DONE;
					end else begin
						quo_q <= quo_nx;
						rem_q <= rem_nx;
						cnt_q <= cnt_q + KW'(1);
					end
				end
				S_DONE: begin
					if (req.take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign num_red   = num_q;
	assign den_red   = den_q;

	`FR_ASSERT(a_start_idle, req.start |-> !stat.busy, "start while engine busy")
	`FR_ASSERT(a_take_done, req.take |-> stat.done, "take without a result")
	`FR_ASSERT_NEXT(a_start_busy, req.start, stat.busy, "start not latched")
	`FR_ASSERT(a_div_nonzero, (state_q == S_DIV_N || state_q == S_DIV_D) |-> (g_q != '0),
		"division by zero gcd")

endmodule

`default_nettype wire

FILE: rtl/core/fraction_reducer.sv
// ----------------------------------------------------------------------------
// fraction_reducer
// Reduces a signed fraction to lowest terms by its greatest common divisor.
// ----------------------------------------------------------------------------
// Usage:
//   frac    : request channel, numerator_in / denominator_in, valid/ready.
//   reduced : result channel, numerator_out / denominator_out, valid/ready.
//   One result per request, in order. If either part is zero or negative
//   the pair comes back unchanged.
// Sequence: a request with a non-positive part goes straight to the done
//   state and on to the output register. Otherwise binary GCD (each
//   cycle one shift, swap or subtract), then two restoring divisions,
//   of the numerator and then of the denominator by the GCD.
//   All of it runs on one shared subtractor.
// Throughput: one request at a time; frac.ready is low from acceptance until
//   the result has moved into the output register.
// Stall: a held result sits in the output register; the next request is
//   accepted meanwhile, and its result waits in the engine until the output
//   register frees.
// Reset: arst_n clears all control state; no request or result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module fraction_reducer
	import fr_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fr_in_if.sink    frac,
	fr_out_if.source reduced
);

	fr_req_t                req;
	fr_stat_t               stat;
	logic [DATA_WIDTH-1:0]  num_red, den_red;
	logic [DATA_WIDTH-1:0]  num_out_q, den_out_q;
	logic                   valid_q;
	logic                   num_pos, den_pos;

	assign num_pos = (frac.numerator_in != '0) && !frac.numerator_in[DATA_WIDTH-1];
	assign den_pos = (frac.denominator_in != '0) && !frac.denominator_in[DATA_WIDTH-1];

	assign frac.ready = !stat.busy;
	assign req.start  = frac.valid && !stat.busy;
	assign req.bypass = !(num_pos && den_pos);
	assign req.take   = stat.done && (!valid_q || reduced.ready);

	fr_engine #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.num     (frac.numerator_in),
		.den     (frac.denominator_in),
		.stat    (stat),
		.num_red (num_red),
		.den_red (den_red)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.take) begin
			valid_q <= 1'b1;
		end else if (reduced.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.take) begin
			num_out_q <= num_red;
			den_out_q <= den_red;
		end
	end

	assign reduced.valid           = valid_q;
	assign reduced.numerator_out   = num_out_q;
	assign reduced.denominator_out = den_out_q;

endmodule

`default_nettype wire

FILE: bench/fraction_reducer_tb.sv
// ----------------------------------------------------------------------------
// fraction_reducer_tb
// Self-checking bench for the fraction reducer. Directed pairs (zero,
// negative, unit and extreme parts, worst-case Euclid chains) and about 2000
// random pairs are pushed through the request channel. A local GCD model
// predicts each reduced pair; results are checked in order, field by field.
// Both sides idle in random bursts, and the result side holds off once for
// a long stretch so the block backs up onto its request channel.
// ----------------------------------------------------------------------------
module fraction_reducer_tb;
	import fr_pkg::*;

	localparam int W          = DATA_WIDTH_DEF;
	localparam int TAIL_ITEMS = 150;
	localparam int DRAIN_CYC  = 400;
	localparam int HOLD_CYC   = 1500;
	localparam int N_RANDOM   = 2000;

	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ALL_ONE = {W{1'b1}};

	typedef struct packed {
		logic [W-1:0] num;
		logic [W-1:0] den;
	} frac_t;

	logic clk;
	logic arst_n;

	fr_in_if  #(.W(W)) frac_ch ();
	fr_out_if #(.W(W)) red_ch ();

	fraction_reducer #(.DATA_WIDTH(W)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frac    (frac_ch),
		.reduced (red_ch)
	);

	frac_t pend_q[$];
	frac_t lowest_q[$];
	int    n_total;
	int    n_accepted;
	int    err_cnt;
	logic  in_taken;
	logic  idle_on;
	int    hold_left;
	logic  hold_done;
	int    src_gap;
	int    snk_gap;
	frac_t drv_item;

	function automatic frac_t lowest_terms(frac_t f);
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] r;
		frac_t        q;
		q = f;
		if (f.num != 0 && !f.num[W-1] && f.den != 0 && !f.den[W-1]) begin
			a = f.num;
			b = f.den;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			q.num = f.num / a;
			q.den = f.den / a;
		end
		return q;
	endfunction

	task automatic flag_mismatch(string what, logic [W-1:0] want, logic [W-1:0] got);
		if (err_cnt < 10)
			$display("mismatch %s: expected %h, got %h (request %0d)", what, want, got,
				n_accepted);
		err_cnt++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n                 = 1'b0;
		frac_ch.valid          = 1'b0;
		frac_ch.numerator_in   = '0;
		frac_ch.denominator_in = '0;
		red_ch.ready           = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// request list
	initial begin : stimulus
		frac_t        f;
		int unsigned  g;
		int unsigned  pick;
		logic [W-1:0] edge_vals[5];

		err_cnt    = 0;
		n_accepted = 0;
		edge_vals  = '{'0, 1, MAX_POS, MIN_NEG, ALL_ONE};

		pend_q.push_back('{num: 0, den: 0});
		pend_q.push_back('{num: 0, den: 5});
		pend_q.push_back('{num: 6, den: 0});
		pend_q.push_back('{num: 1, den: 1});
		pend_q.push_back('{num: 1, den: 7});
		pend_q.push_back('{num: 9, den: 1});
		pend_q.push_back('{num: 6, den: 4});
		pend_q.push_back('{num: 12, den: 18});
		pend_q.push_back('{num: 35, den: 35});
		pend_q.push_back('{num: ALL_ONE, den: 3});
		pend_q.push_back('{num: 3, den: ALL_ONE});
		pend_q.push_back('{num: -6, den: -4});
		pend_q.push_back('{num: MIN_NEG, den: 4});
		pend_q.push_back('{num: 4, den: MIN_NEG});
		pend_q.push_back('{num: MIN_NEG, den: MIN_NEG});
		pend_q.push_back('{num: MAX_POS, den: MAX_POS});
		pend_q.push_back('{num: MAX_POS, den: 1});
		pend_q.push_back('{num: 1, den: MAX_POS});
		pend_q.push_back('{num: MAX_POS, den: MAX_POS - 1});
		pend_q.push_back('{num: MAX_POS, den: 0});
		pend_q.push_back('{num: 32'd1836311903, den: 32'd1134903170});
		pend_q.push_back('{num: 32'h4000_0000, den: 32'h2000_0000});
		pend_q.push_back('{num: 32'h6000_0000, den: 32'h4000_0000});

		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				// shared factor of random size
				g     = $urandom_range(1, 1 << $urandom_range(0, 30));
				f.num = g * $urandom_range(1, MAX_POS / g);
				f.den = g * $urandom_range(1, MAX_POS / g);
			end else if (pick < 60) begin
				f.num = $urandom & MAX_POS;
				f.den = $urandom & MAX_POS;
			end else if (pick < 75) begin
				f.num = $urandom;
				f.den = $urandom;
			end else if (pick < 85) begin
				f.num = $urandom_range(1, 255) << $urandom_range(0, 22);
				f.den = $urandom_range(1, 255) << $urandom_range(0, 22);
			end else if (pick < 95) begin
				f.num = $urandom_range(0, 40) - 20;
				f.den = $urandom_range(0, 40) - 20;
			end else begin
				f.num = edge_vals[$urandom_range(0, 4)];
				f.den = edge_vals[$urandom_range(0, 4)];
			end
			pend_q.push_back(f);
		end
		n_total = pend_q.size();

		wait (arst_n);
		wait (pend_q.size() == 0 && !frac_ch.valid);
		wait (lowest_q.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (lowest_q.size() != 0)
			flag_mismatch("leftover results", lowest_q.size(), 0);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// idle bursts switch on and off in long stretches
	always @(negedge clk) begin
		if (!arst_n) begin
			idle_on <= 1'b1;
		end else if ($urandom_range(0, 499) == 0) begin
			idle_on <= !idle_on;
		end
	end

	// one long hold-off on the result side
	always @(negedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= 40) begin
			hold_left <= HOLD_CYC;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			frac_ch.valid <= 1'b0;
			src_gap = 0;
		end else if (!(frac_ch.valid && !in_taken)) begin
			if (src_gap > 0) begin
				src_gap--;
				frac_ch.valid <= 1'b0;
			end else if (pend_q.size() == 0) begin
				frac_ch.valid <= 1'b0;
			end else if (idle_on && n_accepted + TAIL_ITEMS < n_total &&
					$urandom_range(0, 9) == 0) begin
				src_gap = $urandom_range(0, 16);
				frac_ch.valid <= 1'b0;
			end else begin
				drv_item = pend_q.pop_front();
				frac_ch.valid          <= 1'b1;
				frac_ch.numerator_in   <= drv_item.num;
				frac_ch.denominator_in <= drv_item.den;
			end
		end
	end

	// result side ready
	always @(negedge clk) begin
		if (!arst_n) begin
			red_ch.ready <= 1'b0;
			snk_gap = 0;
		end else if (hold_left != 0) begin
			red_ch.ready <= 1'b0;
		end else if (snk_gap > 0) begin
			snk_gap--;
			red_ch.ready <= 1'b0;
		end else if (idle_on && n_accepted + TAIL_ITEMS < n_total &&
				$urandom_range(0, 7) == 0) begin
			snk_gap = $urandom_range(0, 16);
			red_ch.ready <= 1'b0;
		end else begin
			red_ch.ready <= 1'b1;
		end
	end

	// monitor: predict on request, check on result
	always @(posedge clk) begin : monitor
		frac_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= frac_ch.valid && frac_ch.ready;
			if (frac_ch.valid && frac_ch.ready) begin
				lowest_q.push_back(lowest_terms('{num: frac_ch.numerator_in,
					den: frac_ch.denominator_in}));
				n_accepted++;
			end
			if (red_ch.valid && red_ch.ready) begin
				if (lowest_q.size() == 0) begin
					flag_mismatch("unexpected numerator", 'x, red_ch.numerator_out);
				end else begin
					want = lowest_q.pop_front();
					if (red_ch.numerator_out !== want.num)
						flag_mismatch("numerator", want.num, red_ch.numerator_out);
					if (red_ch.denominator_out !== want.den)
						flag_mismatch("denominator", want.den, red_ch.denominator_out);
				end
			end
		end
	end

endmodule
